// ===== src/svoa_pkg.sv =====
`timescale 1ns / 1ps

package svoa_pkg;

    localparam int VOICES_DEF = 16;
    localparam logic [3:0] PERC_RESET = 4'd9;

    typedef enum logic [1:0] {
        OP_NOTE_ON  = 2'd0,
        OP_NOTE_OFF = 2'd1,
        OP_ALL_OFF  = 2'd2,
        OP_SILENT   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic [3:0]  ch;
        logic [6:0]  note;
        logic [31:0] start;
    } t_voice_rec;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic ev_en;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic immediate;
    } t_stat;

endpackage

// ===== src/svoa_ctrl.sv =====
`timescale 1ns / 1ps

module svoa_ctrl #(
    parameter int VOICES = svoa_pkg::VOICES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  svoa_pkg::t_stat             i_stat,
    output logic                        o_busy,
    output logic                        o_strobe,
    output svoa_pkg::t_cmd              o_cmd,
    output logic [$clog2(VOICES)-1:0]   o_rd_idx,
    output logic [$clog2(VOICES)-1:0]   o_ev_idx
);

    localparam int AW = $clog2(VOICES);
    localparam int CW = $clog2(VOICES + 1);

    svoa_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_idx;
    logic             r_ev_vld;
    logic [AW-1:0]    r_ev_idx;
    logic             r_strobe;
    svoa_pkg::t_cmd   w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= svoa_pkg::ST_IDLE;
            r_idx    <= '0;
            r_ev_vld <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ev_vld <= w_cmd.rd_en;
            r_strobe <= w_cmd.fin;
            if (r_state == svoa_pkg::ST_IDLE) begin
                r_idx <= '0;
            end else if (w_cmd.rd_en) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ev_idx <= r_idx[AW-1:0];
    end

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        w_cmd.ev_en = r_ev_vld;
        unique case (r_state)
            svoa_pkg::ST_IDLE: begin
                if (i_start) begin
                    w_cmd.load = 1'b1;
                    n_state = i_stat.immediate ? svoa_pkg::ST_FIN : svoa_pkg::ST_SCAN;
                end
            end
            svoa_pkg::ST_SCAN: begin
                w_cmd.rd_en = (r_idx < CW'(VOICES));
                if (r_idx == CW'(VOICES)) begin
                    n_state = svoa_pkg::ST_FIN;
                end
            end
            svoa_pkg::ST_FIN: begin
                w_cmd.fin = 1'b1;
                n_state = svoa_pkg::ST_IDLE;
            end
            default: begin
                n_state = svoa_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_cmd    = w_cmd;
    assign o_busy   = (r_state != svoa_pkg::ST_IDLE) || !i_rst_n;
    assign o_strobe = r_strobe;
    assign o_rd_idx = r_idx[AW-1:0];
    assign o_ev_idx = r_ev_idx;

endmodule

// ===== src/svoa_dp.sv =====
`timescale 1ns / 1ps

module svoa_dp #(
    parameter int VOICES = svoa_pkg::VOICES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [3:0]                  i_cfg_wdata,
    input  logic [1:0]                  i_operation,
    input  logic [3:0]                  i_channel,
    input  logic [6:0]                  i_note,
    input  logic [31:0]                 i_now_ms,
    input  logic [3:0]                  i_voice,
    input  svoa_pkg::t_cmd              i_cmd,
    input  logic [$clog2(VOICES)-1:0]   i_rd_idx,
    input  logic [$clog2(VOICES)-1:0]   i_ev_idx,
    output svoa_pkg::t_stat             o_stat,
    output logic                        o_accepted,
    output logic [3:0]                  o_assigned_voice,
    output logic                        o_stolen,
    output logic [15:0]                 o_release_mask
);

    localparam int AW = $clog2(VOICES);

    logic [3:0]           r_perc;
    svoa_pkg::t_op        r_op;
    logic [3:0]           r_ch;
    logic [6:0]           r_note;
    logic [31:0]          r_now;
    logic [3:0]           r_vc;
    logic                 r_ign;

    logic [VOICES-1:0]    r_busy;
    logic [VOICES-1:0]    r_rel;
    svoa_pkg::t_voice_rec r_mem [VOICES];
    svoa_pkg::t_voice_rec r_rd;

    logic                 r_have_idle;
    logic [AW-1:0]        r_idle_idx;
    logic                 r_have_rel;
    logic [AW-1:0]        r_rel_idx;
    logic [31:0]          r_rel_max;
    logic [AW-1:0]        r_bsy_idx;
    logic [31:0]          r_bsy_max;
    logic [VOICES-1:0]    r_mask;

    logic                 r_accepted;
    logic [3:0]           r_assigned;
    logic                 r_stolen;
    logic [15:0]          r_rel_out;

    logic [31:0]          w_life;
    logic                 w_ebusy;
    logic                 w_erel;
    logic                 w_is_rel_op;
    logic                 w_hit;
    logic                 w_rel_set;
    logic                 w_on_scan;
    logic [AW-1:0]        w_pick;
    logic                 w_wr;
    logic                 w_silent;
    logic [AW-1:0]        w_vc_idx;
    logic                 w_in_ign;

    assign w_in_ign = ((i_operation == svoa_pkg::OP_NOTE_ON)
                    || (i_operation == svoa_pkg::OP_NOTE_OFF))
                    && (i_channel == r_perc);
    assign o_stat.immediate = (i_operation == svoa_pkg::OP_SILENT) || w_in_ign;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_perc <= svoa_pkg::PERC_RESET;
        end else if (i_cfg_we) begin
            r_perc <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= svoa_pkg::t_op'(i_operation);
            r_ch   <= i_channel;
            r_note <= i_note;
            r_now  <= i_now_ms;
            r_vc   <= i_voice;
            r_ign  <= w_in_ign;
        end
    end

    // voice record store
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[w_pick] <= '{ch: r_ch, note: r_note, start: r_now};
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[i_rd_idx];
        end
    end

    assign w_life      = r_now - r_rd.start;
    assign w_ebusy     = r_busy[i_ev_idx];
    assign w_erel      = r_rel[i_ev_idx];
    assign w_is_rel_op = (r_op == svoa_pkg::OP_NOTE_OFF) || (r_op == svoa_pkg::OP_ALL_OFF);
    assign w_hit       = w_ebusy && (r_rd.ch == r_ch)
                      && ((r_op == svoa_pkg::OP_ALL_OFF) || (r_rd.note == r_note));
    assign w_rel_set   = i_cmd.ev_en && w_is_rel_op && w_hit;
    assign w_on_scan   = i_cmd.ev_en && (r_op == svoa_pkg::OP_NOTE_ON);

    assign w_pick   = r_have_idle ? r_idle_idx : (r_have_rel ? r_rel_idx : r_bsy_idx);
    assign w_wr     = i_cmd.fin && (r_op == svoa_pkg::OP_NOTE_ON) && !r_ign;
    assign w_silent = i_cmd.fin && (r_op == svoa_pkg::OP_SILENT) && (32'(r_vc) < VOICES);
    assign w_vc_idx = AW'(r_vc);

    // candidate tracking; ties go to the later index
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_have_idle <= 1'b0;
            r_idle_idx  <= '0;
            r_have_rel  <= 1'b0;
            r_rel_idx   <= '0;
            r_rel_max   <= '0;
            r_bsy_idx   <= '0;
            r_bsy_max   <= '0;
            r_mask      <= '0;
        end else begin
            if (w_on_scan) begin
                if (!w_ebusy) begin
                    if (!r_have_idle) begin
                        r_have_idle <= 1'b1;
                        r_idle_idx  <= i_ev_idx;
                    end
                end else if (w_erel) begin
                    if (w_life >= r_rel_max) begin
                        r_have_rel <= 1'b1;
                        r_rel_idx  <= i_ev_idx;
                        r_rel_max  <= w_life;
                    end
                end else if (w_life >= r_bsy_max) begin
                    r_bsy_idx <= i_ev_idx;
                    r_bsy_max <= w_life;
                end
            end
            if (w_rel_set && !w_erel) begin
                r_mask[i_ev_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '0;
            r_rel  <= '0;
        end else begin
            if (w_rel_set) begin
                r_rel[i_ev_idx] <= 1'b1;
            end
            if (w_wr) begin
                r_busy[w_pick] <= 1'b1;
                r_rel[w_pick]  <= 1'b0;
            end
            if (w_silent) begin
                r_busy[w_vc_idx] <= 1'b0;
                r_rel[w_vc_idx]  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_accepted <= !r_ign;
            r_assigned <= w_wr ? 4'(w_pick) : 4'd0;
            r_stolen   <= w_wr && !r_have_idle;
            r_rel_out  <= 16'(r_mask);
        end
    end

    assign o_accepted       = r_accepted;
    assign o_assigned_voice = r_assigned;
    assign o_stolen         = r_stolen;
    assign o_release_mask   = r_rel_out;

endmodule

// ===== src/synth_voice_allocator.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake                Payload
// event     in         start & !busy            i_operation i_channel i_note i_now_ms i_voice
// result    out        o_strobe, one cycle      o_accepted o_assigned_voice o_stolen
//                                               o_release_mask
// config    in         i_cfg_we                 i_cfg_wdata (percussion channel)
//
// Note on, note off and all notes off scan every voice record once, one per cycle,
// through a single-port record store, then pass through a finish state; the
// strobe is registered from that finish state.
// Voice silent and ignored percussion events skip the scan and go straight to the finish state.
// busy is high from accept until the strobe cycle; a new item may start then.
// Synchronous active-low reset frees all voices and sets the percussion channel to 9.
// Results cannot be stalled.

module synth_voice_allocator #(
    parameter int VOICES = svoa_pkg::VOICES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [3:0]  i_channel,
    input  logic [6:0]  i_note,
    input  logic [31:0] i_now_ms,
    input  logic [3:0]  i_voice,
    output logic        o_strobe,
    output logic        o_accepted,
    output logic [3:0]  o_assigned_voice,
    output logic        o_stolen,
    output logic [15:0] o_release_mask
);

    localparam int AW = $clog2(VOICES);

    svoa_pkg::t_cmd  w_cmd;
    svoa_pkg::t_stat w_stat;
    logic [AW-1:0]   w_rd_idx;
    logic [AW-1:0]   w_ev_idx;

    svoa_ctrl #(
        .VOICES (VOICES)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_stat   (w_stat),
        .o_busy   (busy),
        .o_strobe (o_strobe),
        .o_cmd    (w_cmd),
        .o_rd_idx (w_rd_idx),
        .o_ev_idx (w_ev_idx)
    );

    svoa_dp #(
        .VOICES (VOICES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_operation      (i_operation),
        .i_channel        (i_channel),
        .i_note           (i_note),
        .i_now_ms         (i_now_ms),
        .i_voice          (i_voice),
        .i_cmd            (w_cmd),
        .i_rd_idx         (w_rd_idx),
        .i_ev_idx         (w_ev_idx),
        .o_stat           (w_stat),
        .o_accepted       (o_accepted),
        .o_assigned_voice (o_assigned_voice),
        .o_stolen         (o_stolen),
        .o_release_mask   (o_release_mask)
    );

endmodule

// ===== src/svoa_checker.sv =====
`timescale 1ns / 1ps

module svoa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_strobe,
    input logic        o_accepted,
    input logic [3:0]  o_assigned_voice,
    input logic        o_stolen,
    input logic [15:0] o_release_mask
);

    logic w_accept;
    assign w_accept = start && !busy;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("busy low after accept");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_strobe)
        else $error("result in cycle after accept");

    a_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result while busy");

    a_ignored_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_accepted) |->
            (o_release_mask == 16'd0 && !o_stolen && o_assigned_voice == 4'd0))
        else $error("ignored event with nonzero result");

    a_steal_no_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_stolen) |-> (o_release_mask == 16'd0))
        else $error("steal with release mask");

endmodule

bind synth_voice_allocator svoa_checker u_svoa_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_strobe         (o_strobe),
    .o_accepted       (o_accepted),
    .o_assigned_voice (o_assigned_voice),
    .o_stolen         (o_stolen),
    .o_release_mask   (o_release_mask)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import svoa_pkg::*;

    localparam int NV = VOICES_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = NV + 8;

    typedef struct packed {
        t_op         op;
        logic [3:0]  ch;
        logic [6:0]  note;
        logic [31:0] t_ms;
        logic [3:0]  vc;
    } note_event_t;

    typedef struct packed {
        logic        acc;
        logic [3:0]  vc;
        logic        stolen;
        logic [15:0] mask;
    } alloc_result_t;

    typedef struct packed {
        note_event_t   ev;
        logic          typed;
        alloc_result_t res;
    } stim_row_t;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [3:0]  i_cfg_wdata = 4'd0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_operation = 2'd0;
    logic [3:0]  i_channel = 4'd0;
    logic [6:0]  i_note = 7'd0;
    logic [31:0] i_now_ms = 32'd0;
    logic [3:0]  i_voice = 4'd0;
    logic        o_strobe;
    logic        o_accepted;
    logic [3:0]  o_assigned_voice;
    logic        o_stolen;
    logic [15:0] o_release_mask;

    synth_voice_allocator #(.VOICES(NV)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .start(start), .busy(busy),
        .i_operation(i_operation), .i_channel(i_channel), .i_note(i_note),
        .i_now_ms(i_now_ms), .i_voice(i_voice),
        .o_strobe(o_strobe), .o_accepted(o_accepted),
        .o_assigned_voice(o_assigned_voice), .o_stolen(o_stolen),
        .o_release_mask(o_release_mask)
    );

    // allocator state mirror
    logic [3:0]  perc_ch;
    logic        v_busy [NV];
    logic        v_rel [NV];
    logic [3:0]  v_ch [NV];
    logic [6:0]  v_note [NV];
    logic [31:0] v_start [NV];

    alloc_result_t pending_results[$];
    stim_row_t     directed_rows[$];
    int            errors = 0;
    int            cycles = 0;
    int            send_idle_pct = 0;
    logic [31:0]   clock_ms = 32'd0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic alloc_result_t allocate_event(note_event_t ev);
        alloc_result_t r;
        logic          found;
        logic          have_rel;
        int            pick;
        int            pick_busy;
        int            pick_rel;
        logic [31:0]   life;
        logic [31:0]   max_busy;
        logic [31:0]   max_rel;
        r = '0;
        r.acc = 1'b1;
        case (ev.op)
            OP_NOTE_ON: begin
                if (ev.ch == perc_ch) begin
                    r.acc = 1'b0;
                end else begin
                    found = 1'b0;
                    have_rel = 1'b0;
                    pick = 0;
                    pick_busy = 0;
                    pick_rel = 0;
                    max_busy = '0;
                    max_rel = '0;
                    for (int i = 0; i < NV; i++) begin
                        if (!found) begin
                            if (!v_busy[i]) begin
                                found = 1'b1;
                                pick = i;
                            end else begin
                                life = ev.t_ms - v_start[i];
                                if (v_rel[i]) begin
                                    if (life >= max_rel) begin
                                        pick_rel = i;
                                        max_rel = life;
                                        have_rel = 1'b1;
                                    end
                                end else if (life >= max_busy) begin
                                    pick_busy = i;
                                    max_busy = life;
                                end
                            end
                        end
                    end
                    if (!found)
                        pick = have_rel ? pick_rel : pick_busy;
                    r.stolen = !found;
                    r.vc = pick[3:0];
                    v_busy[pick] = 1'b1;
                    v_rel[pick] = 1'b0;
                    v_ch[pick] = ev.ch;
                    v_note[pick] = ev.note;
                    v_start[pick] = ev.t_ms;
                end
            end
            OP_NOTE_OFF, OP_ALL_OFF: begin
                if (ev.op == OP_NOTE_OFF && ev.ch == perc_ch) begin
                    r.acc = 1'b0;
                end else begin
                    for (int i = 0; i < NV; i++) begin
                        if (v_busy[i] && v_ch[i] == ev.ch &&
                            (ev.op == OP_ALL_OFF || v_note[i] == ev.note)) begin
                            if (!v_rel[i])
                                r.mask[i] = 1'b1;
                            v_rel[i] = 1'b1;
                        end
                    end
                end
            end
            default: begin
                if (ev.vc < NV) begin
                    v_busy[ev.vc] = 1'b0;
                    v_rel[ev.vc] = 1'b0;
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin : result_check
        alloc_result_t want;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("result with no item pending");
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_accepted !== want.acc) begin
                    $error("accepted: expected %0d, got %0d", want.acc, o_accepted);
                    errors++;
                end
                if (o_assigned_voice !== want.vc) begin
                    $error("assigned_voice: expected %0d, got %0d", want.vc,
                           o_assigned_voice);
                    errors++;
                end
                if (o_stolen !== want.stolen) begin
                    $error("stolen: expected %0d, got %0d", want.stolen, o_stolen);
                    errors++;
                end
                if (o_release_mask !== want.mask) begin
                    $error("release_mask: expected %h, got %h", want.mask,
                           o_release_mask);
                    errors++;
                end
            end
        end
    end

    task automatic send_item(note_event_t ev, logic typed, alloc_result_t typed_res);
        alloc_result_t r;
        if ($urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 25)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_operation <= ev.op;
        i_channel <= ev.ch;
        i_note <= ev.note;
        i_now_ms <= ev.t_ms;
        i_voice <= ev.vc;
        do @(posedge i_clk); while (busy !== 1'b0);
        r = allocate_event(ev);
        pending_results.push_back(typed ? typed_res : r);
    endtask

    task automatic drain_and_idle();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_perc(logic [3:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        perc_ch = value;
    endtask

    task automatic row(t_op op, logic [3:0] ch, logic [6:0] n, logic [31:0] t,
                       logic [3:0] vc);
        stim_row_t s;
        s = '0;
        s.ev = '{op, ch, n, t, vc};
        directed_rows.push_back(s);
    endtask

    task automatic row_chk(t_op op, logic [3:0] ch, logic [6:0] n, logic [31:0] t,
                           logic [3:0] vc, logic acc, logic [3:0] av, logic st,
                           logic [15:0] m);
        stim_row_t s;
        s.ev = '{op, ch, n, t, vc};
        s.typed = 1'b1;
        s.res = '{acc, av, st, m};
        directed_rows.push_back(s);
    endtask

    task automatic random_event(output note_event_t ev);
        int r;
        int k;
        int j;
        r = $urandom_range(99);
        k = $urandom_range(NV - 1);
        ev.ch = 4'($urandom_range(15));
        ev.note = 7'($urandom_range(127));
        ev.vc = 4'($urandom_range(15));
        if ($urandom_range(49) == 0)
            clock_ms = $urandom;
        else
            clock_ms += $urandom_range(200);
        ev.t_ms = (r % 13 == 0) ? $urandom : clock_ms;
        if (r < 45) begin
            ev.op = OP_NOTE_ON;
            if ($urandom_range(3) != 0)
                ev.note = 7'd60 + 7'($urandom_range(7));
        end else if (r < 75) begin
            ev.op = OP_NOTE_OFF;
            if (v_busy[k] && $urandom_range(4) != 0) begin
                ev.ch = v_ch[k];
                ev.note = v_note[k];
            end
        end else if (r < 82) begin
            ev.op = OP_ALL_OFF;
            if (v_busy[k] && $urandom_range(3) != 0)
                ev.ch = v_ch[k];
        end else begin
            ev.op = OP_SILENT;
            if ($urandom_range(3) != 0) begin
                for (j = NV - 1; j >= 0; j--)
                    if (v_rel[(k + j) % NV])
                        ev.vc = 4'((k + j) % NV);
            end
        end
    endtask

    task automatic run_random(int pct, int count);
        note_event_t ev;
        send_idle_pct = pct;
        for (int n = 0; n < count; n++) begin
            random_event(ev);
            send_item(ev, 1'b0, '0);
        end
        drain_and_idle();
    endtask

    initial begin
        perc_ch = PERC_RESET;
        for (int i = 0; i < NV; i++) begin
            v_busy[i] = 1'b0;
            v_rel[i] = 1'b0;
            v_ch[i] = '0;
            v_note[i] = '0;
            v_start[i] = '0;
        end

        row_chk(OP_NOTE_ON,  4'd9,  7'd127, 32'hFFFF_FFFF, 4'd15, 1'b0, 4'd0, 1'b0, 16'h0);
        row_chk(OP_NOTE_OFF, 4'd9,  7'd127, 32'hFFFF_FFFF, 4'd15, 1'b0, 4'd0, 1'b0, 16'h0);
        row_chk(OP_SILENT,   4'd15, 7'd127, 32'd0,         4'd15, 1'b1, 4'd0, 1'b0, 16'h0);
        row_chk(OP_ALL_OFF,  4'd9,  7'd0,   32'd0,         4'd0,  1'b1, 4'd0, 1'b0, 16'h0);
        row_chk(OP_NOTE_ON,  4'd15, 7'd127, 32'hFFFF_FFF0, 4'd0,  1'b1, 4'd0, 1'b0, 16'h0);
        row(OP_NOTE_ON, 4'd15, 7'd127, 32'hFFFF_FFF0, 4'd0);
        row(OP_NOTE_ON, 4'd0,  7'd0,   32'hFFFF_FFF4, 4'd0);
        row(OP_NOTE_ON, 4'd1,  7'd64,  32'hFFFF_FFF8, 4'd0);
        row(OP_NOTE_ON, 4'd15, 7'd64,  32'hFFFF_FFFC, 4'd0);
        row(OP_NOTE_ON, 4'd2,  7'd1,   32'hFFFF_FFFF, 4'd0);
        row(OP_NOTE_ON, 4'd3,  7'd2,   32'd0,         4'd0);
        row(OP_NOTE_ON, 4'd4,  7'd3,   32'd1,         4'd0);
        row(OP_NOTE_ON, 4'd5,  7'd4,   32'd2,         4'd0);
        row(OP_NOTE_ON, 4'd6,  7'd5,   32'd3,         4'd0);
        row(OP_NOTE_ON, 4'd7,  7'd6,   32'd4,         4'd0);
        row(OP_NOTE_ON, 4'd8,  7'd7,   32'd5,         4'd0);
        row(OP_NOTE_ON, 4'd10, 7'd8,   32'd6,         4'd0);
        row(OP_NOTE_ON, 4'd11, 7'd9,   32'd7,         4'd0);
        row(OP_NOTE_ON, 4'd12, 7'd10,  32'd8,         4'd0);
        row(OP_NOTE_ON, 4'd13, 7'd11,  32'd9,         4'd0);
        // all voices busy: equal oldest lifetimes, the higher index is taken
        row(OP_NOTE_ON,  4'd14, 7'd100, 32'h10, 4'd0);
        row(OP_ALL_OFF,  4'd15, 7'd0,   32'h11, 4'd0);
        row(OP_NOTE_OFF, 4'd15, 7'd127, 32'h12, 4'd0);
        row(OP_NOTE_ON,  4'd1,  7'd65,  32'h20, 4'd0);
        row(OP_SILENT,   4'd0,  7'd0,   32'h21, 4'd4);
        row(OP_NOTE_ON,  4'd12, 7'd127, 32'h30, 4'd0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 17;
        foreach (directed_rows[i])
            send_item(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].res);
        clock_ms = 32'h40;
        drain_and_idle();

        write_perc(4'd0);
        run_random(17, 384);
        write_perc(4'd15);
        run_random(61, 384);
        write_perc(4'($urandom_range(15)));
        run_random(0, 384);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
